// ===== hw/rtl/qft_pkg.sv =====
// Shared types and constants for the quoted field line tokenizer.
`default_nettype none

package qft_pkg;

   // The line ends once this many fields are done.
   localparam logic [6:0] MAX_FIELDS = 7'd64;

   localparam int CSR_ADDR_W = 5;

   localparam logic [7:0] LF     = 8'h0A;
   localparam logic [7:0] CR     = 8'h0D;
   localparam logic [7:0] SQUOTE = 8'h27;
   localparam logic [7:0] DQUOTE = 8'h22;

   localparam logic [2:0] REG_SEPARATOR      = 3'd0;
   localparam logic [2:0] REG_BRACKET_ENABLE = 3'd1;
   localparam logic [2:0] REG_OPEN_CODE      = 3'd2;
   localparam logic [2:0] REG_CLOSE_CODE     = 3'd3;
   localparam logic [2:0] REG_MAX_LINE_LEN   = 3'd4;

   localparam logic [7:0]  RST_SEPARATOR      = 8'd32;
   localparam logic        RST_BRACKET_ENABLE = 1'b0;
   localparam logic [7:0]  RST_OPEN_CODE      = 8'd40;
   localparam logic [7:0]  RST_CLOSE_CODE     = 8'd41;
   localparam logic [15:0] RST_MAX_LINE_LEN   = 16'hFFFF;

   typedef enum logic [6:0] {
      PH_TOP     = 7'b0000001,
      PH_SKIP    = 7'b0000010,
      PH_BRACKET = 7'b0000100,
      PH_QUOTE   = 7'b0001000,
      PH_AFTERQ  = 7'b0010000,
      PH_PLAIN   = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0]  separator;
      logic        bracket_enable;
      logic [7:0]  open_code;
      logic [7:0]  close_code;
      logic [15:0] max_line_len;
   } cfg_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic [5:0] field_index;
      logic       field_end;
      logic       line_end;
      logic [6:0] field_count;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/qft_if.sv =====
// Request and result channel interfaces of the tokenizer.
`default_nettype none

interface qft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface qft_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] out_byte;
   logic [5:0] field_index;
   logic       field_end;
   logic       line_end;
   logic [6:0] field_count;

   modport source (output valid, output has_byte, output out_byte, output field_index,
                   output field_end, output line_end, output field_count, input ready);
   modport sink (input valid, input has_byte, input out_byte, input field_index,
                 input field_end, input line_end, input field_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/quoted_field_line_tokenizer_core.sv =====
// Top level of the quoted field line tokenizer.
`default_nettype none

// The tokenizer takes one byte of a line per request and returns at most one result
// per request: a field byte (sent one request late so a trailing newline or CR can be
// stripped), a field end, or the line end. A request is accepted every clock cycle
// while req_if.ready is high; its result, if any, is presented at the earliest in the
// next cycle. Results wait in a two-entry queue, and ready drops only while it is full,
// which happens only after the result side has stalled. Configuration registers sit on
// the APB port (separator at 0x00, bracket enable at 0x04, open code at 0x08, close code
// at 0x0C, maximum line length at 0x10) and should be written only while no request is
// in flight. A request with end_of_string set closes the line and rearms the block.
module quoted_field_line_tokenizer_core (
   input  logic                           clock,
   input  logic                           reset,
   qft_req_if.sink                        req_if,
   qft_rsp_if.source                      rsp_if,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [qft_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   qft_pkg::cfg_type    cfg;
   qft_pkg::result_type result;
   logic                emit;
   logic                full;
   logic                accept;

   assign req_if.ready = !full;
   assign accept       = req_if.valid && req_if.ready;

   qft_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   qft_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_if.in_byte),
      .end_of_string (req_if.end_of_string),
      .cfg           (cfg),
      .emit          (emit),
      .result        (result)
   );

   qft_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .full      (full),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/qft_csr.sv =====
// APB configuration registers of the tokenizer.
`default_nettype none

module qft_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [qft_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output qft_pkg::cfg_type               cfg
);

   qft_pkg::cfg_type cfg_ff;
   qft_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = paddr[4:2];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            qft_pkg::REG_SEPARATOR:      cfg_in.separator      = pwdata[7:0];
            qft_pkg::REG_BRACKET_ENABLE: cfg_in.bracket_enable = pwdata[0];
            qft_pkg::REG_OPEN_CODE:      cfg_in.open_code      = pwdata[7:0];
            qft_pkg::REG_CLOSE_CODE:     cfg_in.close_code     = pwdata[7:0];
            qft_pkg::REG_MAX_LINE_LEN:   cfg_in.max_line_len   = pwdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         qft_pkg::REG_SEPARATOR:      prdata = {24'd0, cfg_ff.separator};
         qft_pkg::REG_BRACKET_ENABLE: prdata = {31'd0, cfg_ff.bracket_enable};
         qft_pkg::REG_OPEN_CODE:      prdata = {24'd0, cfg_ff.open_code};
         qft_pkg::REG_CLOSE_CODE:     prdata = {24'd0, cfg_ff.close_code};
         qft_pkg::REG_MAX_LINE_LEN:   prdata = {16'd0, cfg_ff.max_line_len};
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator      <= qft_pkg::RST_SEPARATOR;
         cfg_ff.bracket_enable <= qft_pkg::RST_BRACKET_ENABLE;
         cfg_ff.open_code      <= qft_pkg::RST_OPEN_CODE;
         cfg_ff.close_code     <= qft_pkg::RST_CLOSE_CODE;
         cfg_ff.max_line_len   <= qft_pkg::RST_MAX_LINE_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/qft_core.sv =====
// Tokenizer state machine: one request updates the state and yields at most one result.
`default_nettype none

module qft_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                end_of_string,
   input  qft_pkg::cfg_type    cfg,
   output logic                emit,
   output qft_pkg::result_type result
);

   qft_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         quote_char_ff, quote_char_in;
   logic [7:0]         held_byte_ff, held_byte_in;
   logic               held_valid_ff, held_valid_in;
   logic [15:0]        position_ff, position_in;
   logic [6:0]         fields_done_ff, fields_done_in;

   logic [5:0]          idx;
   logic [6:0]          fd_inc;
   logic [15:0]         pos_inc;
   logic                held_nl;
   logic                fe_hb;
   logic                fe_le;
   qft_pkg::result_type end_res;
   qft_pkg::result_type line_res;
   qft_pkg::result_type shift_res;

   assign idx     = (fields_done_ff > 7'd63) ? 6'd63 : fields_done_ff[5:0];
   assign fd_inc  = (fields_done_ff < 7'd127) ? fields_done_ff + 7'd1 : fields_done_ff;
   assign pos_inc = (position_ff != 16'hFFFF) ? position_ff + 16'd1 : position_ff;
   // A newline or CR still held at the end of a field is stripped and ends the line.
   assign held_nl = held_valid_ff &&
                    (held_byte_ff == qft_pkg::LF || held_byte_ff == qft_pkg::CR);
   assign fe_hb   = held_valid_ff && !held_nl;
   assign fe_le   = held_nl || (fd_inc >= qft_pkg::MAX_FIELDS);

   always_comb begin
      end_res.has_byte    = fe_hb;
      end_res.out_byte    = fe_hb ? held_byte_ff : 8'd0;
      end_res.field_index = idx;
      end_res.field_end   = 1'b1;
      end_res.line_end    = fe_le;
      end_res.field_count = fd_inc;

      line_res.has_byte    = 1'b0;
      line_res.out_byte    = 8'd0;
      line_res.field_index = idx;
      line_res.field_end   = 1'b0;
      line_res.line_end    = 1'b1;
      line_res.field_count = fields_done_ff;

      shift_res.has_byte    = 1'b1;
      shift_res.out_byte    = held_byte_ff;
      shift_res.field_index = idx;
      shift_res.field_end   = 1'b0;
      shift_res.line_end    = 1'b0;
      shift_res.field_count = fields_done_ff;
   end

   always_comb begin
      phase_in       = phase_ff;
      quote_char_in  = quote_char_ff;
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      position_in    = position_ff;
      fields_done_in = fields_done_ff;
      emit           = 1'b0;
      result         = line_res;

      if (accept && end_of_string) begin
         if (phase_ff == qft_pkg::PH_TOP || phase_ff == qft_pkg::PH_SKIP) begin
            emit = 1'b1;
         end else if (phase_ff != qft_pkg::PH_DONE) begin
            emit            = 1'b1;
            result          = end_res;
            result.line_end = 1'b1;
         end
         phase_in       = qft_pkg::PH_TOP;
         quote_char_in  = 8'd0;
         held_byte_in   = 8'd0;
         held_valid_in  = 1'b0;
         position_in    = 16'd0;
         fields_done_in = 7'd0;
      end else if (accept) begin
         position_in = pos_inc;
         case (phase_ff)
            qft_pkg::PH_TOP, qft_pkg::PH_SKIP: begin
               // The length bound is checked only where a field would begin: at line start
               // or after a field end.
               if (phase_ff == qft_pkg::PH_TOP && position_ff >= cfg.max_line_len) begin
                  emit        = 1'b1;
                  phase_in    = qft_pkg::PH_DONE;
                  position_in = position_ff;
               end else if (in_byte == cfg.separator) begin
                  phase_in = qft_pkg::PH_SKIP;
               end else if (in_byte == qft_pkg::LF || in_byte == qft_pkg::CR) begin
                  emit     = 1'b1;
                  phase_in = qft_pkg::PH_DONE;
               end else if (cfg.bracket_enable && in_byte == cfg.open_code) begin
                  phase_in      = qft_pkg::PH_BRACKET;
                  held_valid_in = 1'b0;
               end else if (in_byte == qft_pkg::SQUOTE || in_byte == qft_pkg::DQUOTE) begin
                  phase_in      = qft_pkg::PH_QUOTE;
                  quote_char_in = in_byte;
                  held_byte_in  = in_byte;
                  held_valid_in = 1'b1;
               end else begin
                  phase_in      = qft_pkg::PH_PLAIN;
                  held_byte_in  = in_byte;
                  held_valid_in = 1'b1;
               end
            end
            qft_pkg::PH_BRACKET, qft_pkg::PH_PLAIN: begin
               if ((phase_ff == qft_pkg::PH_BRACKET && in_byte == cfg.close_code) ||
                   (phase_ff == qft_pkg::PH_PLAIN && in_byte == cfg.separator)) begin
                  emit           = 1'b1;
                  result         = end_res;
                  fields_done_in = fd_inc;
                  held_valid_in  = 1'b0;
                  held_byte_in   = 8'd0;
                  phase_in       = fe_le ? qft_pkg::PH_DONE : qft_pkg::PH_TOP;
               end else begin
                  emit          = held_valid_ff;
                  result        = shift_res;
                  held_byte_in  = in_byte;
                  held_valid_in = 1'b1;
               end
            end
            qft_pkg::PH_QUOTE: begin
               emit          = held_valid_ff;
               result        = shift_res;
               held_byte_in  = in_byte;
               held_valid_in = 1'b1;
               if (in_byte == quote_char_ff) begin
                  phase_in = qft_pkg::PH_AFTERQ;
               end
            end
            qft_pkg::PH_AFTERQ: begin
               // The byte after the closing quote is consumed whatever it is.
               emit           = 1'b1;
               result         = end_res;
               fields_done_in = fd_inc;
               held_valid_in  = 1'b0;
               held_byte_in   = 8'd0;
               phase_in       = fe_le ? qft_pkg::PH_DONE : qft_pkg::PH_TOP;
            end
            default: begin
               position_in = position_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= qft_pkg::PH_TOP;
         quote_char_ff  <= 8'd0;
         held_byte_ff   <= 8'd0;
         held_valid_ff  <= 1'b0;
         position_ff    <= 16'd0;
         fields_done_ff <= 7'd0;
      end else begin
         phase_ff       <= phase_in;
         quote_char_ff  <= quote_char_in;
         held_byte_ff   <= held_byte_in;
         held_valid_ff  <= held_valid_in;
         position_ff    <= position_in;
         fields_done_ff <= fields_done_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == qft_pkg::PH_DONE) |-> !held_valid_ff)
      else $error("held byte left over after the line ended");

   assert property (@(posedge clock) disable iff (reset)
      fields_done_ff <= qft_pkg::MAX_FIELDS)
      else $error("field count ran past the field limit");

   assert property (@(posedge clock) disable iff (reset) emit |-> accept)
      else $error("result produced without an accepted request");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/qft_rsp_queue.sv =====
// Two-entry result queue that decouples the result channel from request acceptance.
`default_nettype none

module qft_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qft_pkg::result_type push_data,
   output logic                full,
   qft_rsp_if.source           rsp
);

   qft_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;
   qft_pkg::result_type head;

   assign pop       = rsp.valid && rsp.ready;
   assign full      = (count_ff == 2'd2);
   assign head      = entry_ff[rd_ptr_ff];
   assign rsp.valid = (count_ff != 2'd0);

   assign rsp.has_byte    = head.has_byte;
   assign rsp.out_byte    = head.out_byte;
   assign rsp.field_index = head.field_index;
   assign rsp.field_end   = head.field_end;
   assign rsp.line_end    = head.line_end;
   assign rsp.field_count = head.field_count;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("result pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue occupancy did not grow on push");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == {1'b0, wr_ptr_ff ^ rd_ptr_ff}) ||
      (count_ff == 2'd2 && wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");
`endif

endmodule

`default_nettype wire
